### rtl/vssr_pkg.sv
// Shared types, command codes and status codes of the value stack.
package vssr_pkg;

  // Default number of entries
  localparam int unsigned DEPTH_DEF = 16;

  // Widths fixed by the port fields
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 5;

  // Command codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // Result beat handed from the sequencer to the output stage
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 found;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

endpackage

### rtl/vssr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module vssr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/vssr_ctrl.sv
// Command sequencer: push/pop/clear, top-down scan and gap-closing shift over the RAM.
module vssr_ctrl import vssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // command beat
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value,
  // result beat
  output logic                    res_valid,
  input  logic                    res_ready,
  output res_t                    res,
  // entry memory
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [VAL_W-1:0]        mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic [VAL_W-1:0]        mem_rdata
);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic              rem_r, rem_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              found_r, found_nxt;

  logic [AW-1:0]     idx_inc;
  logic [AW-1:0]     idx_dec;
  logic              more_above;

  assign idx_inc    = idx_r + AW'(1);
  assign idx_dec    = idx_r - AW'(1);
  // another entry sits above the current index
  assign more_above = (CW'(idx_r) + CW'(1)) < count_r;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res.status      = stat_r;
  assign res.found       = found_r;
  assign res.entry_count = CNT_OUT_W'(count_r);

  // Next-state and memory access logic
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    value_nxt = value_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    stat_nxt  = stat_r;
    found_nxt = found_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = in_value;
    mem_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt = in_value;
          rem_nxt   = (in_op == OP_REMOVE);
          stat_nxt  = ST_OK;
          found_nxt = 1'b0;
          state_nxt = S_RESP;
          case (in_op)
            OP_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                stat_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                stat_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_SEARCH, OP_REMOVE: begin
              if (count_r == '0) begin
                stat_nxt = ST_NOT_FOUND;
              end else begin
                // start at the top entry
                mem_raddr = AW'(count_r - CW'(1));
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // one entry compared per cycle, walking down from the top
      S_SCAN: begin
        if (mem_rdata == value_r) begin
          found_nxt = 1'b1;
          if (rem_r && more_above) begin
            mem_raddr = idx_inc;
            idx_nxt   = idx_inc;
            state_nxt = S_SHIFT;
          end else begin
            if (rem_r) begin
              count_nxt = count_r - CW'(1);
            end
            state_nxt = S_RESP;
          end
        end else if (idx_r == '0) begin
          stat_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          mem_raddr = idx_dec;
          idx_nxt   = idx_dec;
        end
      end

      // move each entry above the gap down by one
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_dec;
        mem_wdata = mem_rdata;
        if (more_above) begin
          mem_raddr = idx_inc;
          idx_nxt   = idx_inc;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
  end

endmodule

### rtl/value_stack_search_remove.sv
// Top level of the value stack with search and remove by value.
//
// A bounded stack of DEPTH signed 32-bit values kept in one synchronous RAM.
// Each command beat returns one result beat. Search reads one entry per
// cycle from the top down; remove then moves each entry above the match
// down by one to close the gap, so a match near the bottom is the slow
// case. The scan and the shift are paced by the RAM's single read port,
// which delivers one entry per cycle. A result register at the output lets
// the next command be accepted while a result waits.
module value_stack_search_remove import vssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OP_W-1:0]             in_op,
  input  logic signed [VAL_W-1:0]     in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [STAT_W-1:0]           out_status,
  output logic                        out_found,
  output logic [CNT_OUT_W-1:0]        out_entry_count
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  vssr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vssr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_value  (in_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_found       = out_res_r.found;
  assign out_entry_count = out_res_r.entry_count;

endmodule

### rtl/vssr_checker.sv
// Port-level checks on the value stack's result beats, bound to the top level.
module vssr_checker import vssr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STAT_W-1:0]    out_status,
  input logic                 out_found,
  input logic [CNT_OUT_W-1:0] out_entry_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // a located value always comes with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found set with non-ok status");

  // empty status only on an empty store
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0 && !out_found)
    else $error("empty status with entries held");

  // full status only when the store holds DEPTH entries
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNT_OUT_W'(DEPTH))
    else $error("full status with wrong count");

endmodule

bind value_stack_search_remove vssr_checker #(
  .DEPTH (DEPTH)
) u_vssr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_entry_count (out_entry_count)
);
